>>> rtl/core/tfuv_pkg.sv
// tfuv_pkg: types and constants shared by the text field UTF-8 validator.
// Holds the input/result item structs, the queue entry struct and status codes.
// No dependencies.
`default_nettype none

package tfuv_pkg;

    // Field kinds; also the index of the matching limit register.
    localparam logic [2:0] KIND_OPERATION   = 3'd0;
    localparam logic [2:0] KIND_NAME        = 3'd1;
    localparam logic [2:0] KIND_VERSION     = 3'd2;
    localparam logic [2:0] KIND_DESCRIPTION = 3'd3;
    localparam logic [2:0] KIND_CAPABILITY  = 3'd4;

    localparam int unsigned NUM_LIMITS = 5;

    // Limit register reset values (truncated to the limit width at use).
    localparam logic [31:0] RST_MAX_OPERATION   = 32'd128;
    localparam logic [31:0] RST_MAX_NAME        = 32'd128;
    localparam logic [31:0] RST_MAX_VERSION     = 32'd64;
    localparam logic [31:0] RST_MAX_DESCRIPTION = 32'd1024;
    localparam logic [31:0] RST_MAX_CAPABILITY  = 32'd128;

    // Byte classes
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] BYTE_DOT   = 8'h2E;
    localparam logic [7:0] BYTE_UNDER = 8'h5F;
    localparam logic [7:0] BYTE_DASH  = 8'h2D;
    localparam logic [7:0] BYTE_LC_A  = 8'h61;
    localparam logic [7:0] BYTE_LC_Z  = 8'h7A;
    localparam logic [7:0] BYTE_D0    = 8'h30;
    localparam logic [7:0] BYTE_D9    = 8'h39;

    // Code point bounds
    localparam logic [20:0] CP_MIN_2   = 21'h00080;
    localparam logic [20:0] CP_MIN_3   = 21'h00800;
    localparam logic [20:0] CP_MIN_4   = 21'h10000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] CP_SUR_LO  = 21'h0D800;
    localparam logic [20:0] CP_SUR_HI  = 21'h0DFFF;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_EMPTY         = 3'd1,
        ST_TOO_LONG      = 3'd2,
        ST_INVALID_TEXT  = 3'd3,
        ST_EMPTY_SEGMENT = 3'd4,
        ST_NOT_CANONICAL = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0] field_kind;
        logic       has_byte;
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [2:0] kind_out;
    } t_out_item;

    // Classified byte, as queued between front and back.
    typedef struct packed {
        logic [2:0] kind;
        logic       has_byte;
        logic       last;
        logic       is_ctrl;
        logic       is_dot;
        logic       is_canon;
        logic       is_cont;
        logic       lead_bad;
        logic [1:0] lead_cnt;   // continuations announced by a lead byte
        logic [4:0] lead_bits;  // payload bits of a lead byte
        logic [5:0] cont_bits;  // payload bits of a continuation byte
    } t_cls;

endpackage

`default_nettype wire

>>> rtl/core/tfuv_front.sv
// tfuv_front: input handshake and per-byte classification.
// Depends on tfuv_pkg.
`default_nettype none

module tfuv_front (
    input  wire                tfuv_pkg::t_in_item i_item,
    input  wire                i_valid,
    input  wire                i_full,
    output logic               o_stall,
    output logic               o_push,
    output tfuv_pkg::t_cls     o_cls
);

    logic [7:0] b;

    assign b       = i_item.data_byte;
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cls           = '0;
        o_cls.kind      = i_item.field_kind;
        o_cls.has_byte  = i_item.has_byte;
        o_cls.last      = i_item.last;
        o_cls.is_ctrl   = (b < tfuv_pkg::BYTE_SPACE) || (b == tfuv_pkg::BYTE_DEL);
        o_cls.is_dot    = (b == tfuv_pkg::BYTE_DOT);
        o_cls.is_canon  = ((b >= tfuv_pkg::BYTE_LC_A) && (b <= tfuv_pkg::BYTE_LC_Z)) ||
                          ((b >= tfuv_pkg::BYTE_D0) && (b <= tfuv_pkg::BYTE_D9)) ||
                          (b == tfuv_pkg::BYTE_DOT) || (b == tfuv_pkg::BYTE_UNDER) ||
                          (b == tfuv_pkg::BYTE_DASH);
        o_cls.is_cont   = (b[7:6] == 2'b10);
        o_cls.cont_bits = b[5:0];
        // lead byte decode
        unique casez (b)
            8'b0???????: begin
                o_cls.lead_cnt = 2'd0;
            end
            8'b110?????: begin
                o_cls.lead_cnt  = 2'd1;
                o_cls.lead_bits = b[4:0];
            end
            8'b1110????: begin
                o_cls.lead_cnt  = 2'd2;
                o_cls.lead_bits = {1'b0, b[3:0]};
            end
            8'b11110???: begin
                o_cls.lead_cnt  = 2'd3;
                o_cls.lead_bits = {2'b00, b[2:0]};
            end
            default: begin
                o_cls.lead_bad = 1'b1;  // stray continuation or 0xF8..0xFF
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/tfuv_queue.sv
// tfuv_queue: small flop-based FIFO between front and back.
// Depends on tfuv_pkg only through its users; generic in width and depth.
`default_nettype none

module tfuv_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_empty,
    output logic             o_full
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_count != CNT_W'(DEPTH)))
        else $error("queue pushed while full");

endmodule

`default_nettype wire

>>> rtl/core/tfuv_back.sv
// tfuv_back: UTF-8 decode state, length count, dot/charset flags and status.
// Pops classified bytes from the queue; holds the result in an output register.
// Depends on tfuv_pkg.
`default_nettype none

module tfuv_back #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  wire                                              i_clk,
    input  wire                                              i_rst_n,
    input  wire  tfuv_pkg::t_cls                             i_head,
    input  wire                                              i_empty,
    output logic                                             o_pop,
    input  wire  [tfuv_pkg::NUM_LIMITS-1:0][LENGTH_BITS-1:0] i_limits,
    output logic                                             o_out_valid,
    input  wire                                              i_out_stall,
    output tfuv_pkg::t_out_item                              o_out_item
);

    localparam int unsigned CNT_W = LENGTH_BITS + 1;

    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       r_pend, n_pend;
    logic [1:0]       r_seq, n_seq;
    logic [20:0]      r_acc, n_acc;
    logic             r_text_err, n_text_err;
    logic             r_seg_err, n_seg_err;
    logic             r_chr_err, n_chr_err;
    logic             r_prev_dot, n_prev_dot;

    logic                r_out_valid;
    tfuv_pkg::t_out_item r_out_item;

    logic                out_free;
    logic                ident;
    logic [CNT_W-1:0]    limit;
    logic [20:0]         cp;
    logic                cp_bad;
    tfuv_pkg::t_status   status;

    // Non-last bytes always drain; a last byte waits for the result slot.
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = !i_empty && (!i_head.last || out_free);

    assign ident = (i_head.kind == tfuv_pkg::KIND_OPERATION) ||
                   (i_head.kind == tfuv_pkg::KIND_CAPABILITY);
    assign limit = (i_head.kind < 3'(tfuv_pkg::NUM_LIMITS)) ?
                   {1'b0, i_limits[i_head.kind]} : '0;

    // Code point completed by the current continuation byte.
    assign cp     = {r_acc[14:0], i_head.cont_bits};
    assign cp_bad = ((r_seq == 2'd1) && (cp < tfuv_pkg::CP_MIN_2)) ||
                    ((r_seq == 2'd2) && (cp < tfuv_pkg::CP_MIN_3)) ||
                    ((r_seq == 2'd3) && (cp < tfuv_pkg::CP_MIN_4)) ||
                    (cp > tfuv_pkg::CP_MAX) ||
                    ((cp >= tfuv_pkg::CP_SUR_LO) && (cp <= tfuv_pkg::CP_SUR_HI));

    always_comb begin
        n_count    = r_count;
        n_pend     = r_pend;
        n_seq      = r_seq;
        n_acc      = r_acc;
        n_text_err = r_text_err;
        n_seg_err  = r_seg_err;
        n_chr_err  = r_chr_err;
        n_prev_dot = r_prev_dot;
        status     = tfuv_pkg::ST_OK;

        if (o_pop && i_head.has_byte) begin
            if (i_head.is_ctrl) begin
                n_text_err = 1'b1;
            end
            if ((r_pend != 2'd0) && i_head.is_cont) begin
                n_acc  = cp;
                n_pend = r_pend - 1'b1;
                if (r_pend == 2'd1) begin
                    n_seq = 2'd0;
                    if (cp_bad) begin
                        n_text_err = 1'b1;
                    end
                end
            end else begin
                // abandon an interrupted sequence, then treat as a lead byte
                if (r_pend != 2'd0) begin
                    n_text_err = 1'b1;
                    n_pend     = 2'd0;
                    n_seq      = 2'd0;
                end
                if (i_head.lead_bad) begin
                    n_text_err = 1'b1;
                end else if (i_head.lead_cnt != 2'd0) begin
                    n_pend = i_head.lead_cnt;
                    n_seq  = i_head.lead_cnt;
                    n_acc  = {16'd0, i_head.lead_bits};
                end
            end
            if (i_head.is_dot && ((r_count == '0) || r_prev_dot)) begin
                n_seg_err = 1'b1;
            end
            if (!i_head.is_canon) begin
                n_chr_err = 1'b1;
            end
            n_prev_dot = i_head.is_dot;
            if (!r_count[CNT_W-1]) begin
                n_count = r_count + 1'b1;
            end
        end

        priority if (n_count == '0) begin
            status = tfuv_pkg::ST_EMPTY;
        end else if (n_count > limit) begin
            status = tfuv_pkg::ST_TOO_LONG;
        end else if (n_text_err || (n_pend != 2'd0)) begin
            status = tfuv_pkg::ST_INVALID_TEXT;
        end else if (ident && (n_seg_err || n_prev_dot)) begin
            status = tfuv_pkg::ST_EMPTY_SEGMENT;
        end else if (ident && n_chr_err) begin
            status = tfuv_pkg::ST_NOT_CANONICAL;
        end else begin
            status = tfuv_pkg::ST_OK;
        end

        if (o_pop && i_head.last) begin
            n_count    = '0;
            n_pend     = 2'd0;
            n_seq      = 2'd0;
            n_acc      = '0;
            n_text_err = 1'b0;
            n_seg_err  = 1'b0;
            n_chr_err  = 1'b0;
            n_prev_dot = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 2'd0;
            r_seq       <= 2'd0;
            r_acc       <= '0;
            r_text_err  <= 1'b0;
            r_seg_err   <= 1'b0;
            r_chr_err   <= 1'b0;
            r_prev_dot  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_pend     <= n_pend;
            r_seq      <= n_seq;
            r_acc      <= n_acc;
            r_text_err <= n_text_err;
            r_seg_err  <= n_seg_err;
            r_chr_err  <= n_chr_err;
            r_prev_dot <= n_prev_dot;
            if (o_pop && i_head.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_out_item.status   <= status;
            r_out_item.kind_out <= i_head.kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_field_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_head.last) |=> ((r_count == '0) && (r_pend == 2'd0) && !r_text_err))
        else $error("field state not cleared after last byte");

    a_pend_within_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= r_seq)
        else $error("pending continuations exceed sequence length");

endmodule

`default_nettype wire

>>> rtl/core/text_field_utf8_validator.sv
// text_field_utf8_validator: top level of the text field validator.
// Instantiates tfuv_front, tfuv_queue and tfuv_back; holds the limit registers.
// Depends on tfuv_pkg.
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+------------------------------
//  in       | in        | i_in_valid / o_in_stall      | i_in_item  (tfuv_pkg::t_in_item)
//  out      | out       | o_out_valid / i_out_stall    | o_out_item (tfuv_pkg::t_out_item)
//  cfg      | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  One item per cycle while nothing stalls: the front classifies a byte and pushes it
//  into a QUEUE_DEPTH-entry queue, and the back pops one queued byte per cycle.
//  When nothing stalls, the status of a field passes through the queue entry,
//  written when its last item is accepted, and then the output register, written
//  when the back pops that entry, before it is on o_out.
//  Reset (synchronous, active low) clears field state and the queue and loads the
//  default limits; no clearing pass is needed.
//  A stalled status holds the back only at the next last byte; earlier bytes keep
//  draining, and the input stalls once the queue is full.
//  Configuration is always ready; a write to an index past the list is ignored.
`default_nettype none

module text_field_utf8_validator #(
    parameter int unsigned LENGTH_BITS = 16,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // item input
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  tfuv_pkg::t_in_item     i_in_item,
    // status output
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output tfuv_pkg::t_out_item          o_out_item,
    // configuration writes
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [2:0]                   i_cfg_index,
    input  wire  [LENGTH_BITS-1:0]       i_cfg_data
);

    localparam int unsigned CLS_W = $bits(tfuv_pkg::t_cls);

    logic [tfuv_pkg::NUM_LIMITS-1:0][LENGTH_BITS-1:0] r_limits;

    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    tfuv_pkg::t_cls cls_in;
    tfuv_pkg::t_cls cls_head;
    logic [CLS_W-1:0] head_bits;

    assign o_cfg_ready = 1'b1;

    // Limit registers; index equals the field kind they serve.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits[tfuv_pkg::KIND_OPERATION] <=
                tfuv_pkg::RST_MAX_OPERATION[LENGTH_BITS-1:0];
            r_limits[tfuv_pkg::KIND_NAME] <=
                tfuv_pkg::RST_MAX_NAME[LENGTH_BITS-1:0];
            r_limits[tfuv_pkg::KIND_VERSION] <=
                tfuv_pkg::RST_MAX_VERSION[LENGTH_BITS-1:0];
            r_limits[tfuv_pkg::KIND_DESCRIPTION] <=
                tfuv_pkg::RST_MAX_DESCRIPTION[LENGTH_BITS-1:0];
            r_limits[tfuv_pkg::KIND_CAPABILITY] <=
                tfuv_pkg::RST_MAX_CAPABILITY[LENGTH_BITS-1:0];
        end else if (i_cfg_valid && o_cfg_ready &&
                     (i_cfg_index < 3'(tfuv_pkg::NUM_LIMITS))) begin
            r_limits[i_cfg_index] <= i_cfg_data;
        end
    end

    // Front: handshake and byte classification
    tfuv_front u_front (
        .i_item  (i_in_item),
        .i_valid (i_in_valid),
        .i_full  (q_full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_cls   (cls_in)
    );

    // Decoupling queue
    tfuv_queue #(
        .WIDTH (CLS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .i_pop   (pop),
        .o_head  (head_bits),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign cls_head = tfuv_pkg::t_cls'(head_bits);

    // Back: decode state, flags, status and result register
    tfuv_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (cls_head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_limits    (r_limits),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    a_result_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!q_empty))
        else $error("status produced with no queued item");

endmodule

`default_nettype wire
